@@ rtl/skdt_pkg.sv @@
package skdt_pkg;

  // defaults for the top-level parameters
  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 64;

  // fixed field widths
  localparam int HASH_W       = 64;
  localparam int CMD_W        = 2;
  localparam int KEY_W        = 8;
  localparam int STATUS_W     = 2;
  localparam int SLOT_W       = 10;
  localparam int TE_W         = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;
  localparam logic [TE_W-1:0] TE_RESET = 11'd1024;

  // modulo unit: remainder bits resolved per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = HASH_W / DIV_BITS;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTER_MODE  = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_FILL = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_MODE  = 2'd1,
    STAT_NOVAL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ACT,
    ST_RD,
    ST_FILL,
    ST_RES
  } state_t;

endpackage

@@ rtl/skdt_in_if.sv @@
interface skdt_in_if #(
  parameter int VALUE_WIDTH = skdt_pkg::VALUE_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [skdt_pkg::CMD_W-1:0]   command;
  logic [skdt_pkg::KEY_W-1:0]   key_byte;
  logic                         key_last;
  logic [VALUE_WIDTH-1:0]       entry_value;
  logic                         value_present;

  modport source (
    output valid, command, key_byte, key_last, entry_value, value_present,
    input  ready
  );
  modport sink (
    input  valid, command, key_byte, key_last, entry_value, value_present,
    output ready
  );
endinterface

@@ rtl/skdt_out_if.sv @@
interface skdt_out_if #(
  parameter int VALUE_WIDTH = skdt_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [skdt_pkg::STATUS_W-1:0] status;
  logic [VALUE_WIDTH-1:0]        read_value;
  logic                          found;
  logic [skdt_pkg::SLOT_W-1:0]   slot;

  modport source (
    output valid, status, read_value, found, slot,
    input  ready
  );
  modport sink (
    input  valid, status, read_value, found, slot,
    output ready
  );
endinterface

@@ rtl/skdt_cfg_if.sv @@
interface skdt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [skdt_pkg::CFG_IDX_W-1:0]  index;
  logic [skdt_pkg::CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ rtl/string_keyed_direct_table_top.sv @@
// Set and get first run the modulo (4 bits per cycle) in ST_DIV, then the slot access in
// ST_ACT; get then adds a registered RAM read in ST_RD. Fill walks the slots in use in
// ST_FILL; a refused fill goes straight to ST_RES. Every result waits in ST_RES for the
// output register to free. Throughput: 1 non-final key byte per cycle while idle; a new
// request is taken only once the last result has gone to the output register.
// Reset (sync, active low) starts a clearing pass over all MAX_ENTRIES slots; no request until it ends.
module string_keyed_direct_table_top #(
  parameter int MAX_ENTRIES = skdt_pkg::MAX_ENTRIES_DEF,
  parameter int VALUE_WIDTH = skdt_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  skdt_in_if.sink    in_if,
  skdt_out_if.source out_if,
  skdt_cfg_if.sink   cfg_if
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMP_W  = (CNT_W > skdt_pkg::TE_W) ? CNT_W : skdt_pkg::TE_W;
  localparam int STEP_W = $clog2(skdt_pkg::DIV_STEPS);
  localparam int HW     = skdt_pkg::HASH_W;

  // hash fold: h * 97 + b, zero byte leaves the hash alone
  function automatic logic [HW-1:0] fold(input logic [HW-1:0] h,
                                         input logic [skdt_pkg::KEY_W-1:0] b);
    logic [HW-1:0] m;
    m = (h << 6) + (h << 5) + h;
    if (b == '0) fold = h;
    else fold = m + HW'(b);
  endfunction

  skdt_pkg::state_t state_r, state_nxt;

  logic [HW-1:0]                 hash_r, hash_nxt;
  logic [HW-1:0]                 dvd_r, dvd_nxt;
  logic [CNT_W-1:0]              rem_r, rem_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic [CNT_W-1:0]              walk_r, walk_nxt;
  logic [skdt_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [VALUE_WIDTH-1:0]        val_r, val_nxt;
  logic                          pres_r, pres_nxt;
  logic [skdt_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [VALUE_WIDTH-1:0]        res_value_r, res_value_nxt;
  logic                          res_found_r, res_found_nxt;
  logic [skdt_pkg::SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [skdt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VALUE_WIDTH-1:0]        out_value_r, out_value_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [skdt_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;

  logic [skdt_pkg::TE_W-1:0]     table_entries_r;
  logic                          pointer_mode_r;

  logic [VALUE_WIDTH-1:0]        mem [MAX_ENTRIES];
  logic [VALUE_WIDTH-1:0]        mem_q_r;
  logic                          mem_we, mem_re;
  logic [ADDR_W-1:0]             mem_addr;
  logic [VALUE_WIDTH-1:0]        mem_wdata;

  logic [CNT_W-1:0]              n_cur;
  logic [CNT_W-1:0]              div_rem;
  logic [CNT_W+skdt_pkg::SLOT_W-1:0] slot_ext;
  logic [HW-1:0]                 hash_fold;

  // slots in use: zero acts as one, clamp at the table size
  always_comb begin
    logic [CMP_W-1:0] te_w;
    logic [CMP_W-1:0] max_w;
    te_w  = CMP_W'(table_entries_r);
    max_w = CMP_W'(MAX_ENTRIES);
    if (te_w == '0) begin
      n_cur = CNT_W'(1);
    end else if (te_w > max_w) begin
      n_cur = CNT_W'(max_w);
    end else begin
      n_cur = CNT_W'(te_w);
    end
  end

  // restoring modulo step, DIV_BITS dividend bits per cycle
  always_comb begin
    logic [CNT_W:0] r;
    r = {1'b0, rem_r};
    for (int k = 0; k < skdt_pkg::DIV_BITS; k++) begin
      r = {r[CNT_W-1:0], dvd_r[HW-1-k]};
      if (r >= {1'b0, n_cur}) r = r - {1'b0, n_cur};
    end
    div_rem = r[CNT_W-1:0];
  end

  assign slot_ext  = {{skdt_pkg::SLOT_W{1'b0}}, rem_r};
  assign hash_fold = fold(hash_r, in_if.key_byte);

  // configuration writes, always ready
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_entries_r <= skdt_pkg::TE_RESET;
      pointer_mode_r  <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        skdt_pkg::CFG_TABLE_ENTRIES: table_entries_r <= cfg_if.data[skdt_pkg::TE_W-1:0];
        skdt_pkg::CFG_POINTER_MODE:  pointer_mode_r  <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // sequencer: next state, RAM control and register updates
  always_comb begin
    state_nxt      = state_r;
    hash_nxt       = hash_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    walk_nxt       = walk_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    pres_nxt       = pres_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_found_nxt  = res_found_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_found_nxt  = out_found_r;
    out_slot_nxt   = out_slot_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = rem_r[ADDR_W-1:0];
    mem_wdata      = val_r;
    in_if.ready    = 1'b0;

    case (state_r)
      skdt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = walk_r[ADDR_W-1:0];
        mem_wdata = '0;
        walk_nxt  = walk_r + CNT_W'(1);
        if (walk_r == CNT_W'(MAX_ENTRIES - 1)) begin
          walk_nxt  = '0;
          state_nxt = skdt_pkg::ST_IDLE;
        end
      end

      skdt_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          case (in_if.command)
            skdt_pkg::CMD_SET, skdt_pkg::CMD_GET: begin
              if (in_if.key_last) begin
                dvd_nxt   = hash_fold;
                hash_nxt  = '0;
                rem_nxt   = '0;
                step_nxt  = '0;
                cmd_nxt   = in_if.command;
                val_nxt   = in_if.entry_value;
                pres_nxt  = in_if.value_present;
                state_nxt = skdt_pkg::ST_DIV;
              end else begin
                hash_nxt = hash_fold;
              end
            end
            skdt_pkg::CMD_FILL: begin
              val_nxt       = in_if.entry_value;
              res_value_nxt = '0;
              res_found_nxt = 1'b0;
              res_slot_nxt  = '0;
              if (!in_if.value_present) begin
                res_status_nxt = skdt_pkg::STAT_NOVAL;
                state_nxt      = skdt_pkg::ST_RES;
              end else if (pointer_mode_r) begin
                res_status_nxt = skdt_pkg::STAT_MODE;
                state_nxt      = skdt_pkg::ST_RES;
              end else begin
                walk_nxt  = '0;
                state_nxt = skdt_pkg::ST_FILL;
              end
            end
            default: ;
          endcase
        end
      end

      skdt_pkg::ST_DIV: begin
        rem_nxt  = div_rem;
        dvd_nxt  = dvd_r << skdt_pkg::DIV_BITS;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(skdt_pkg::DIV_STEPS - 1)) state_nxt = skdt_pkg::ST_ACT;
      end

      // slot known: write for set (none for a value-mode set with no value), issue the read for get
      skdt_pkg::ST_ACT: begin
        res_slot_nxt   = slot_ext[skdt_pkg::SLOT_W-1:0];
        res_value_nxt  = '0;
        res_found_nxt  = 1'b0;
        res_status_nxt = skdt_pkg::STAT_OK;
        if (cmd_r == skdt_pkg::CMD_SET) begin
          state_nxt = skdt_pkg::ST_RES;
          if (pointer_mode_r) begin
            mem_we    = 1'b1;
            mem_wdata = pres_r ? val_r : '0;
          end else if (!pres_r) begin
            res_status_nxt = skdt_pkg::STAT_NOVAL;
          end else begin
            mem_we = 1'b1;
          end
        end else begin
          mem_re    = 1'b1;
          state_nxt = skdt_pkg::ST_RD;
        end
      end

      skdt_pkg::ST_RD: begin
        res_value_nxt = mem_q_r;
        res_found_nxt = pointer_mode_r ? (mem_q_r != '0) : 1'b1;
        state_nxt     = skdt_pkg::ST_RES;
      end

      skdt_pkg::ST_FILL: begin
        mem_we   = 1'b1;
        mem_addr = walk_r[ADDR_W-1:0];
        walk_nxt = walk_r + CNT_W'(1);
        if (walk_r == n_cur - CNT_W'(1)) begin
          walk_nxt       = '0;
          res_status_nxt = skdt_pkg::STAT_OK;
          state_nxt      = skdt_pkg::ST_RES;
        end
      end

      // hand the result to the output register once it is free
      skdt_pkg::ST_RES: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_found_nxt  = res_found_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = skdt_pkg::ST_IDLE;
        end
      end

      default: state_nxt = skdt_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skdt_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= '0;
      step_r      <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hash_r      <= hash_nxt;
      step_r      <= step_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    pres_r       <= pres_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_found_r  <= res_found_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_found_r  <= out_found_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // slot RAM, single port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_q_r <= mem[mem_addr];
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.read_value = out_value_r;
  assign out_if.found      = out_found_r;
  assign out_if.slot       = out_slot_r;

`ifndef SYNTHESIS
  // modulo result lies inside the table in use
  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skdt_pkg::ST_ACT |-> rem_r < n_cur)
    else $error("slot index not below slot count");

  // fill walk never leaves the slots in use
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skdt_pkg::ST_FILL |-> walk_r < n_cur)
    else $error("fill walk out of range");

  // no RAM write while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skdt_pkg::ST_IDLE |-> !mem_we)
    else $error("RAM write in idle");

  // final byte of set/get starts the modulo unit with the hash cleared
  a_last_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.key_last &&
     (in_if.command == skdt_pkg::CMD_SET || in_if.command == skdt_pkg::CMD_GET))
    |=> (state_r == skdt_pkg::ST_DIV && hash_r == '0))
    else $error("final key byte did not start modulo");
`endif

endmodule

@@ tb/sv/string_keyed_direct_table_top_tb.sv @@
module string_keyed_direct_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HASH_W     = skdt_pkg::HASH_W;
  localparam int CMD_W      = skdt_pkg::CMD_W;
  localparam int KEY_W      = skdt_pkg::KEY_W;
  localparam int STATUS_W   = skdt_pkg::STATUS_W;
  localparam int SLOT_W     = skdt_pkg::SLOT_W;
  localparam int TE_W       = skdt_pkg::TE_W;
  localparam int CFG_IDX_W  = skdt_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = skdt_pkg::CFG_DATA_W;

  localparam int MAX_SLOTS = skdt_pkg::MAX_ENTRIES_DEF;
  localparam int VAL_W     = skdt_pkg::VALUE_WIDTH_DEF;
  localparam logic [HASH_W-1:0] HASH_MULT = 64'd97;
  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam int LONG_STALL_CYCLES = 600;
  localparam int SETTLE_CYCLES     = 40;
  localparam int SHOW_LIMIT        = 10;

  typedef enum {FLOW_FREE, FLOW_SEND_SLOW, FLOW_RECV_SLOW, FLOW_BOTH_LIGHT} flow_t;

  typedef struct {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key_byte;
    logic             key_last;
    logic [VAL_W-1:0] entry_value;
    logic             value_present;
  } table_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    read_value;
    logic                found;
    logic [SLOT_W-1:0]   slot;
  } table_resp_t;

  logic clk;
  logic rst_n;

  skdt_in_if  #(.VALUE_WIDTH(VAL_W)) in_bus ();
  skdt_out_if #(.VALUE_WIDTH(VAL_W)) out_bus ();
  skdt_cfg_if                        cfg_bus ();

  string_keyed_direct_table_top #(
    .MAX_ENTRIES(MAX_SLOTS),
    .VALUE_WIDTH(VAL_W)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus),
    .cfg_if(cfg_bus)
  );

  // shadow of the table state
  logic [HASH_W-1:0] key_hash;
  logic [VAL_W-1:0]  slot_mem [MAX_SLOTS];
  logic [TE_W-1:0]   tbl_entries;
  logic              ptr_mode;

  table_req_t  pending_reqs[$];
  table_resp_t expected_results[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  recv_hold;
  bit  long_stall_go;
  bit  req_taken;

  int  err_count;
  int  shown;
  int  reqs_accepted;
  int  results_checked;
  int  n_set, n_get, n_fill, n_ignored;
  int  n_settings;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // effective slot count: 0 acts as 1, oversize clamps
  function automatic logic [HASH_W-1:0] slots_used();
    if (tbl_entries == '0) return HASH_W'(1);
    if (int'(tbl_entries) > MAX_SLOTS) return HASH_W'(MAX_SLOTS);
    return HASH_W'(tbl_entries);
  endfunction

  // fold one request into the shadow table, queue the response it causes
  function automatic void predict_request(table_req_t r);
    logic [HASH_W-1:0] n;
    logic [HASH_W-1:0] idx;
    table_resp_t e;
    n = slots_used();
    e.status = skdt_pkg::STAT_OK;
    e.read_value = '0;
    e.found = 1'b0;
    e.slot = '0;
    if (r.command == CMD_UNUSED) begin
      n_ignored++;
      return;
    end
    if (r.command == skdt_pkg::CMD_FILL) begin
      n_fill++;
      if (!r.value_present) e.status = skdt_pkg::STAT_NOVAL;
      else if (ptr_mode) e.status = skdt_pkg::STAT_MODE;
      else for (int i = 0; i < n; i++) slot_mem[i] = r.entry_value;
    end else begin
      if (r.key_byte != 0) key_hash = key_hash * HASH_MULT + HASH_W'(r.key_byte);
      if (!r.key_last) return;
      idx = key_hash % n;
      key_hash = '0;
      e.slot = idx[SLOT_W-1:0];
      if (r.command == skdt_pkg::CMD_SET) begin
        n_set++;
        if (ptr_mode) slot_mem[idx] = r.value_present ? r.entry_value : '0;
        else if (!r.value_present) e.status = skdt_pkg::STAT_NOVAL;
        else slot_mem[idx] = r.entry_value;
      end else begin
        n_get++;
        e.read_value = slot_mem[idx];
        e.found = ptr_mode ? (slot_mem[idx] != '0) : 1'b1;
      end
    end
    expected_results.push_back(e);
  endfunction

  // request driver: holds valid until taken, idles at random between requests
  always @(negedge clk) begin : req_driver
    table_req_t r;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        in_bus.command       <= r.command;
        in_bus.key_byte      <= r.key_byte;
        in_bus.key_last      <= r.key_last;
        in_bus.entry_value   <= r.entry_value;
        in_bus.value_present <= r.value_present;
        in_bus.valid         <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // response sink backpressure
  always @(negedge clk) begin
    out_bus.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin : long_stall
    wait (long_stall_go);
    @(posedge clk);
    recv_hold = 1'b1;
    repeat (LONG_STALL_CYCLES) @(posedge clk);
    recv_hold = 1'b0;
  end

  // monitor: predict on request accept, check on response accept
  always @(posedge clk) begin : monitor
    table_req_t  seen;
    table_resp_t want;
    req_taken <= in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        seen.command       = in_bus.command;
        seen.key_byte      = in_bus.key_byte;
        seen.key_last      = in_bus.key_last;
        seen.entry_value   = in_bus.entry_value;
        seen.value_present = in_bus.value_present;
        reqs_accepted++;
        predict_request(seen);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          err_count++;
          if (shown < SHOW_LIMIT) begin
            shown++;
            $display("%0t: response with none pending: status %0d value %h found %0b slot %0d",
                     $realtime, out_bus.status, out_bus.read_value, out_bus.found,
                     out_bus.slot);
          end
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_bus.status !== want.status || out_bus.read_value !== want.read_value ||
              out_bus.found !== want.found || out_bus.slot !== want.slot) begin
            err_count++;
            if (shown < SHOW_LIMIT) begin
              shown++;
              $display("%0t: mismatch: expected status %0d value %h found %0b slot %0d",
                       $realtime, want.status, want.read_value, want.found, want.slot);
              $display("%0t:           got status %0d value %h found %0b slot %0d",
                       $realtime, out_bus.status, out_bus.read_value, out_bus.found,
                       out_bus.slot);
            end
          end
        end
      end
    end
  end

  function automatic void push_req(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] kb, logic last,
                                   logic [VAL_W-1:0] val, logic present);
    table_req_t r;
    r.command       = cmd;
    r.key_byte      = kb;
    r.key_last      = last;
    r.entry_value   = val;
    r.value_present = present;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return VAL_W'($urandom_range(1, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void set_flow(flow_t f);
    case (f)
      FLOW_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      FLOW_SEND_SLOW:  begin send_idle_pct = 74; recv_stall_pct = 0;  end
      FLOW_RECV_SLOW:  begin send_idle_pct = 0;  recv_stall_pct = 74; end
      FLOW_BOTH_LIGHT: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      default:         begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  // mostly well-formed keys with random content, some noise and broken keys
  function automatic void gen_random_traffic(int count);
    int made;
    int len;
    int roll;
    int fill_pct;
    logic [CMD_W-1:0] op;
    logic [VAL_W-1:0] v;
    logic present;
    logic [KEY_W-1:0] kb;
    made = 0;
    fill_pct = (slots_used() <= 64) ? 4 : 1;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      if (roll < fill_pct) begin
        push_req(skdt_pkg::CMD_FILL, KEY_W'($urandom), 1'($urandom), rand_value(),
                 $urandom_range(0, 9) != 0);
        made++;
      end else if (roll < fill_pct + 4) begin
        // unused command, ignored by the block
        push_req(CMD_UNUSED, KEY_W'($urandom), 1'($urandom), rand_value(), 1'($urandom));
      end else if (roll < fill_pct + 8) begin
        // stray non-final byte, leaves the hash mid-key
        push_req(CMD_W'($urandom_range(0, 1)), KEY_W'($urandom), 1'b0, rand_value(),
                 1'($urandom));
        made++;
      end else begin
        len = $urandom_range(1, 5);
        op = CMD_W'($urandom_range(0, 1));
        v = rand_value();
        present = ($urandom_range(0, 6) != 0);
        for (int b = 0; b < len; b++) begin
          kb = ($urandom_range(0, 9) == 0) ? '0 : KEY_W'($urandom);
          push_req(($urandom_range(0, 19) == 0) ? {1'b0, ~op[0]} : op, kb, b == len - 1,
                   v, present);
          made++;
        end
      end
    end
  endfunction

  // wait until the block has nothing in flight
  task automatic drain_block();
    while (pending_reqs.size() != 0 || in_bus.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == skdt_pkg::CFG_TABLE_ENTRIES) tbl_entries = data[TE_W-1:0];
    else if (idx == skdt_pkg::CFG_POINTER_MODE) ptr_mode = data[0];
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [TE_W-1:0] entries, input logic mode, input flow_t f,
                           input int count, input bit long_hold);
    drain_block();
    cfg_write(skdt_pkg::CFG_TABLE_ENTRIES, CFG_DATA_W'(entries));
    cfg_write(skdt_pkg::CFG_POINTER_MODE, CFG_DATA_W'(mode));
    n_settings++;
    set_flow(f);
    if (long_hold) long_stall_go = 1'b1;
    gen_random_traffic(count);
    drain_block();
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.command = skdt_pkg::CMD_SET;
    in_bus.key_byte = '0;
    in_bus.key_last = 1'b0;
    in_bus.entry_value = '0;
    in_bus.value_present = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = skdt_pkg::CFG_TABLE_ENTRIES;
    cfg_bus.data = '0;
    recv_hold = 1'b0;
    long_stall_go = 1'b0;
    req_taken = 1'b0;
    key_hash = '0;
    tbl_entries = skdt_pkg::TE_RESET;
    ptr_mode = 1'b0;
    for (int k = 0; k < MAX_SLOTS; k++) slot_mem[k] = '0;
    set_flow(FLOW_FREE);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, value mode at reset settings
    push_req(skdt_pkg::CMD_SET, 8'h41, 1'b1, '1, 1'b1);
    push_req(skdt_pkg::CMD_GET, 8'h41, 1'b1, '0, 1'b1);
    push_req(skdt_pkg::CMD_SET, 8'hFF, 1'b0, '0, 1'b0);
    push_req(skdt_pkg::CMD_SET, 8'hFF, 1'b1, '0, 1'b0);           // missing value
    push_req(skdt_pkg::CMD_GET, 8'h00, 1'b1, '0, 1'b0);           // empty key
    push_req(skdt_pkg::CMD_SET, 8'h00, 1'b0, 64'h1234_5678_9ABC_DEF0, 1'b1);
    push_req(skdt_pkg::CMD_SET, 8'h41, 1'b1, 64'h1234_5678_9ABC_DEF0, 1'b1);
    push_req(CMD_UNUSED, 8'h41, 1'b1, '1, 1'b1);
    push_req(skdt_pkg::CMD_GET, 8'h41, 1'b1, '0, 1'b0);
    push_req(skdt_pkg::CMD_FILL, 8'h00, 1'b0, '1, 1'b0);          // fill with no value
    push_req(skdt_pkg::CMD_FILL, 8'hFF, 1'b1, 64'h8000_0000_0000_0001, 1'b1);
    push_req(skdt_pkg::CMD_GET, 8'h10, 1'b0, '0, 1'b0);
    push_req(CMD_UNUSED, 8'h77, 1'b0, '0, 1'b0);                  // mid-key, no effect
    push_req(skdt_pkg::CMD_GET, 8'h20, 1'b1, '0, 1'b0);
    drain_block();

    // directed, pointer mode with a single slot
    cfg_write(skdt_pkg::CFG_POINTER_MODE, CFG_DATA_W'(1));
    cfg_write(skdt_pkg::CFG_TABLE_ENTRIES, CFG_DATA_W'(1));
    n_settings++;
    push_req(skdt_pkg::CMD_SET, 8'h7F, 1'b1, '1, 1'b0);           // null store
    push_req(skdt_pkg::CMD_GET, 8'h01, 1'b1, '0, 1'b0);
    push_req(skdt_pkg::CMD_SET, 8'h02, 1'b1, 64'd5, 1'b1);
    push_req(skdt_pkg::CMD_GET, 8'h03, 1'b1, '0, 1'b0);
    push_req(skdt_pkg::CMD_FILL, 8'h00, 1'b0, '1, 1'b1);          // refused in pointer mode
    push_req(skdt_pkg::CMD_FILL, 8'h00, 1'b0, '1, 1'b0);
    push_req(skdt_pkg::CMD_SET, 8'h04, 1'b1, '0, 1'b1);
    push_req(skdt_pkg::CMD_GET, 8'h05, 1'b1, '0, 1'b0);

    // random phases over table sizes, modes and flow patterns
    run_phase(11'd7,    1'b0, FLOW_FREE,       150, 1'b0);
    run_phase(11'd1,    1'b1, FLOW_SEND_SLOW,  110, 1'b0);
    run_phase(11'd1024, 1'b0, FLOW_RECV_SLOW,  130, 1'b0);
    run_phase(11'd0,    1'b0, FLOW_BOTH_LIGHT, 100, 1'b0);
    run_phase(11'd33,   1'b1, FLOW_BOTH_LIGHT, 110, 1'b0);
    run_phase(11'd2047, 1'b1, FLOW_FREE,       90,  1'b0);
    run_phase(TE_W'($urandom_range(3, 64)), 1'b0, FLOW_SEND_SLOW, 100, 1'b0);
    run_phase(11'd2,    1'b0, FLOW_RECV_SLOW,  90,  1'b0);
    run_phase(11'd16,   1'b0, FLOW_FREE,       100, 1'b1);

    drain_block();
    if (expected_results.size() != 0) begin
      err_count += expected_results.size();
      $display("%0d responses never arrived", expected_results.size());
    end

    $display("Run covered %0d requests (%0d set, %0d get, %0d fill, %0d ignored), %0d checked",
             reqs_accepted, n_set, n_get, n_fill, n_ignored, results_checked);
    $display("over %0d table settings, with throttled and long-stalled traffic; %0d failures",
             n_settings, err_count);
    if (err_count == 0) begin
      $display("PASS string_keyed_direct_table_top");
    end else begin
      $display("FAIL string_keyed_direct_table_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20_000_000);
    $display("FAIL string_keyed_direct_table_top");
    $finish;
  end

endmodule
